>>> rtl/core/crv_pkg.sv
// ----------------------------------------------------------------------------
// crv_pkg
// Shared types and constants for the record validator: record layout,
// magic bytes, checksum polynomial, status codes and channel payloads.
// ----------------------------------------------------------------------------
package crv_pkg;

    // Record layout, in byte positions
    localparam int COUNT_W = 5;
    localparam logic [COUNT_W-1:0] MAGIC_BYTES  = 5'd8;
    localparam logic [COUNT_W-1:0] SCHEMA_START = 5'd12;
    localparam logic [COUNT_W-1:0] GEN_START    = 5'd16;
    localparam logic [COUNT_W-1:0] CRC_SPAN     = 5'd24;
    localparam logic [COUNT_W-1:0] RECORD_BYTES = 5'd28;
    localparam logic [COUNT_W-1:0] COUNT_SAT    = 5'd29;

    localparam logic [7:0] MAGIC [8] = '{
        8'h49, 8'h4E, 8'h4E, 8'h42, 8'h43, 8'h55, 8'h52, 8'h31
    };

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_FORMAT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCHEMA = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SIZE     = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_CHECKSUM = 3'd3,
        ST_FORMAT   = 3'd4,
        ST_SCHEMA   = 3'd5,
        ST_GEN_ZERO = 3'd6
    } crv_status_t;

    typedef struct packed {
        logic [7:0] record_byte;
        logic       last_byte;
    } crv_in_t;

    typedef struct packed {
        crv_status_t status;
        logic [31:0] format_version;
        logic [31:0] schema_version;
        logic [63:0] generation;
    } crv_out_t;

endpackage

>>> rtl/core/crv_stream_if.sv
// ----------------------------------------------------------------------------
// crv_stream_if
// Valid/ready channel carrying one item per accepted handshake.
// ----------------------------------------------------------------------------
interface crv_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

>>> rtl/core/current_record_validator.sv
// ----------------------------------------------------------------------------
// current_record_validator
// Byte-serial checker for a fixed 28-byte record with magic and CRC-32.
// ----------------------------------------------------------------------------
// Usage:
//   record  - sink channel, one byte per item, last_byte flags the final byte.
//   result  - source channel, one status item per flagged byte, none otherwise.
//   cfg_*   - write port for the expected format and schema versions; write
//             only while no record is in flight and no result is pending.
// Throughput: one byte per cycle. All checks for a byte are settled in the
//   cycle it is accepted; the only limit is the two-entry result buffer.
// Result: a flagged byte's status is registered into the output register, or
//   into the skid entry while the output register holds a status not taken.
// Stall: a non-flagged byte never needs a result slot. The output register
//   plus one skid entry let the block keep taking bytes while a status waits;
//   record.ready drops only when both entries are full.
// Reset: clears the per-record state (count, CRC, captured fields), empties
//   the result buffer and sets both expected versions to 1.
// Length: the count saturates at 29; a flag at any count other than 28 gives
//   a size error with zeroed fields. Bytes past the 28th are only counted.
// ----------------------------------------------------------------------------
module current_record_validator
    import crv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    crv_stream_if.sink             record,
    crv_stream_if.source           result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic [31:0] exp_format_reg;
    logic [31:0] exp_schema_reg;

    // Per-record state
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [31:0]        crc_reg, crc_next;
    logic               magic_good_reg, magic_good_next;
    logic [31:0]        format_reg, format_next;
    logic [31:0]        schema_reg, schema_next;
    logic [63:0]        gen_reg, gen_next;
    logic [31:0]        stored_crc_reg, stored_crc_next;

    // Result buffer: output register and skid entry
    logic     out_valid_reg;
    crv_out_t out_data_reg;
    logic     skid_valid_reg;
    crv_out_t skid_data_reg;

    logic        accept;
    logic        push;
    logic        pop;
    logic [7:0]  rx_byte;
    logic [31:0] crc_stepped;
    logic        size_ok;
    crv_out_t    new_result;

    assign rx_byte = record.payload.record_byte;

    // Hold off new bytes only when both result entries are occupied.
    assign record.ready = !skid_valid_reg;
    assign accept       = record.valid && record.ready;
    assign push         = accept && record.payload.last_byte;
    assign pop          = out_valid_reg && result.ready;

    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

    crv_crc_byte u_crc_byte (
        .crc_in  (crc_reg),
        .data    (rx_byte),
        .crc_out (crc_stepped)
    );

    // Advance the record state by the byte on the input.
    always_comb
    begin
        magic_good_next = magic_good_reg;
        crc_next        = crc_reg;
        format_next     = format_reg;
        schema_next     = schema_reg;
        gen_next        = gen_reg;
        stored_crc_next = stored_crc_reg;

        if (count_reg < RECORD_BYTES)
        begin
            if (count_reg < MAGIC_BYTES && rx_byte != MAGIC[count_reg[2:0]])
            begin
                magic_good_next = 1'b0;
            end
            if (count_reg < CRC_SPAN)
            begin
                crc_next = crc_stepped;
            end
            // Fields arrive little-endian: shift each new byte in at the top.
            priority if (count_reg < MAGIC_BYTES)
            begin
            end
            else if (count_reg < SCHEMA_START)
            begin
                format_next = {rx_byte, format_reg[31:8]};
            end
            else if (count_reg < GEN_START)
            begin
                schema_next = {rx_byte, schema_reg[31:8]};
            end
            else if (count_reg < CRC_SPAN)
            begin
                gen_next = {rx_byte, gen_reg[63:8]};
            end
            else
            begin
                stored_crc_next = {rx_byte, stored_crc_reg[31:8]};
            end
        end

        count_next = (count_reg < COUNT_SAT) ? count_reg + 1'b1 : count_reg;
    end

    // Status of the record if this byte is the flagged one, first failure wins.
    always_comb
    begin
        size_ok = (count_next == RECORD_BYTES);

        priority if (!size_ok)
            new_result.status = ST_SIZE;
        else if (!magic_good_next)
            new_result.status = ST_MAGIC;
        else if ((crc_next ^ CRC_INIT) != stored_crc_next)
            new_result.status = ST_CHECKSUM;
        else if (format_next != exp_format_reg)
            new_result.status = ST_FORMAT;
        else if (schema_next != exp_schema_reg)
            new_result.status = ST_SCHEMA;
        else if (gen_next == 64'd0)
            new_result.status = ST_GEN_ZERO;
        else
            new_result.status = ST_OK;

        new_result.format_version = size_ok ? format_next : 32'd0;
        new_result.schema_version = size_ok ? schema_next : 32'd0;
        new_result.generation     = size_ok ? gen_next    : 64'd0;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_format_reg <= 32'd1;
            exp_schema_reg <= 32'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FORMAT: exp_format_reg <= cfg_data;
                REG_SCHEMA: exp_schema_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Record state: advance on each byte, drop back to the start after the flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            crc_reg        <= CRC_INIT;
            magic_good_reg <= 1'b1;
            format_reg     <= '0;
            schema_reg     <= '0;
            gen_reg        <= '0;
            stored_crc_reg <= '0;
        end
        else if (accept)
        begin
            if (record.payload.last_byte)
            begin
                count_reg      <= '0;
                crc_reg        <= CRC_INIT;
                magic_good_reg <= 1'b1;
                format_reg     <= '0;
                schema_reg     <= '0;
                gen_reg        <= '0;
                stored_crc_reg <= '0;
            end
            else
            begin
                count_reg      <= count_next;
                crc_reg        <= crc_next;
                magic_good_reg <= magic_good_next;
                format_reg     <= format_next;
                schema_reg     <= schema_next;
                gen_reg        <= gen_next;
                stored_crc_reg <= stored_crc_next;
            end
        end
    end

    // Result buffer control. A push with the skid full cannot happen since
    // record.ready is low then.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= new_result;
            end
            else
            begin
                out_data_reg <= new_result;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_skid_behind_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg
    ) else $error("skid entry holds a result while the output register is empty");

    a_flag_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        push |=> out_valid_reg
    ) else $error("flagged byte accepted but no result presented");

    a_count_saturates: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_SAT
    ) else $error("byte count ran past its saturation value");

    a_size_error_zeroes: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status == ST_SIZE) |->
            (out_data_reg.generation == 64'd0 && out_data_reg.format_version == 32'd0)
    ) else $error("size error result carries decoded fields");

endmodule

>>> rtl/core/crv_crc_byte.sv
// ----------------------------------------------------------------------------
// crv_crc_byte
// One byte of reflected CRC-32: xor in the byte, then eight shift steps.
// ----------------------------------------------------------------------------
module crv_crc_byte
    import crv_pkg::*;
(
    input  logic [31:0] crc_in,
    input  logic [7:0]  data,
    output logic [31:0] crc_out
);

    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc_out = c;
    end

endmodule

>>> tb/sv/crv_result_checker.sv
// ----------------------------------------------------------------------------
// Record validator checker
// Watches the record and result channels and the register write port of the
// record validator. Rebuilds every status from the bytes it sees accepted and
// compares each returned status, field by field, in order of arrival.
// ----------------------------------------------------------------------------
package crv_tb_pkg;

    // "INNBCUR1", the leading bytes of every well-formed record
    localparam logic [7:0] RECORD_MAGIC [8] = '{
        8'h49, 8'h4E, 8'h4E, 8'h42, 8'h43, 8'h55, 8'h52, 8'h31
    };

    localparam logic [31:0] CRC32_POLY = 32'hEDB88320;

    // Reflected CRC-32, one byte at a time, no final inversion
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
        return c;
    endfunction

endpackage

module crv_result_checker
    import crv_pkg::*;
    import crv_tb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rec_valid,
    input  logic                   rec_ready,
    input  crv_in_t                rec_item,
    input  logic                   res_valid,
    input  logic                   res_ready,
    input  crv_out_t               res_item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     pending,
    output int                     checked,
    output logic [6:0]             statuses_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FMT_AT     = 8;
    localparam int SCH_AT     = 12;
    localparam int GEN_AT     = 16;
    localparam int TRAILER_AT = 24;
    localparam int REC_LEN    = 28;

    // Running picture of the record in flight
    int          seen_bytes;
    logic [31:0] crc_run;
    logic        magic_match;
    logic [31:0] fmt_field;
    logic [31:0] sch_field;
    logic [63:0] gen_field;
    logic [31:0] crc_field;

    logic [31:0] fmt_want;
    logic [31:0] sch_want;

    crv_out_t status_q[$];

    always @(posedge clk or negedge rst_n) begin : predict_and_compare
        crv_out_t want;
        logic     full_len;
        if (!rst_n) begin
            seen_bytes    = 0;
            crc_run       = '1;
            magic_match   = 1'b1;
            fmt_field     = '0;
            sch_field     = '0;
            gen_field     = '0;
            crc_field     = '0;
            fmt_want      = 32'd1;
            sch_want      = 32'd1;
            status_q.delete();
            mismatches    = 0;
            checked       = 0;
            pending       = 0;
            statuses_seen = '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_FORMAT)
                    fmt_want = cfg_data;
                else if (cfg_index == REG_SCHEMA)
                    sch_want = cfg_data;
            end

            // Results leave in the cycle after their byte at the earliest, so
            // retire before absorbing this edge's byte.
            if (res_valid && res_ready) begin
                if (status_q.size() == 0) begin
                    mismatches++;
                    $display("t=%0t unexpected result: status %0d with nothing expected",
                             $time, res_item.status);
                end else begin
                    want = status_q.pop_front();
                    checked++;
                    statuses_seen[res_item.status] = 1'b1;
                    if (res_item.status !== want.status) begin
                        mismatches++;
                        $display("t=%0t status: expected %0d, got %0d",
                                 $time, want.status, res_item.status);
                    end
                    if (res_item.format_version !== want.format_version) begin
                        mismatches++;
                        $display("t=%0t format_version: expected %h, got %h",
                                 $time, want.format_version, res_item.format_version);
                    end
                    if (res_item.schema_version !== want.schema_version) begin
                        mismatches++;
                        $display("t=%0t schema_version: expected %h, got %h",
                                 $time, want.schema_version, res_item.schema_version);
                    end
                    if (res_item.generation !== want.generation) begin
                        mismatches++;
                        $display("t=%0t generation: expected %h, got %h",
                                 $time, want.generation, res_item.generation);
                    end
                end
            end

            if (rec_valid && rec_ready) begin
                if (seen_bytes < REC_LEN) begin
                    if (seen_bytes < FMT_AT && rec_item.record_byte != RECORD_MAGIC[seen_bytes])
                        magic_match = 1'b0;
                    if (seen_bytes < TRAILER_AT)
                        crc_run = crc32_byte(crc_run, rec_item.record_byte);
                    // Fields are little-endian: shift in from the top
                    if (seen_bytes >= FMT_AT && seen_bytes < SCH_AT)
                        fmt_field = {rec_item.record_byte, fmt_field[31:8]};
                    else if (seen_bytes >= SCH_AT && seen_bytes < GEN_AT)
                        sch_field = {rec_item.record_byte, sch_field[31:8]};
                    else if (seen_bytes >= GEN_AT && seen_bytes < TRAILER_AT)
                        gen_field = {rec_item.record_byte, gen_field[63:8]};
                    else if (seen_bytes >= TRAILER_AT)
                        crc_field = {rec_item.record_byte, crc_field[31:8]};
                end
                // Saturate one past the record length
                if (seen_bytes < REC_LEN + 1)
                    seen_bytes++;

                if (rec_item.last_byte) begin
                    full_len = (seen_bytes == REC_LEN);
                    if (!full_len)
                        want.status = ST_SIZE;
                    else if (!magic_match)
                        want.status = ST_MAGIC;
                    else if (~crc_run != crc_field)
                        want.status = ST_CHECKSUM;
                    else if (fmt_field != fmt_want)
                        want.status = ST_FORMAT;
                    else if (sch_field != sch_want)
                        want.status = ST_SCHEMA;
                    else if (gen_field == '0)
                        want.status = ST_GEN_ZERO;
                    else
                        want.status = ST_OK;
                    want.format_version = full_len ? fmt_field : '0;
                    want.schema_version = full_len ? sch_field : '0;
                    want.generation     = full_len ? gen_field : '0;
                    status_q = {status_q, want};

                    seen_bytes  = 0;
                    crc_run     = '1;
                    magic_match = 1'b1;
                    fmt_field   = '0;
                    sch_field   = '0;
                    gen_field   = '0;
                    crc_field   = '0;
                end
            end
            pending = status_q.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Record validator testbench
// Feeds 28-byte records, byte by byte, into the record validator: a directed
// set of good, short, overlong and corrupted records, then random records
// under three idle mixes and several version settings. The checker beside
// the block predicts and compares every status; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crv_pkg::*;
    import crv_tb_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 7;
    localparam int HOLD_CYCLES   = 150;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BYTES   = 30;
    localparam int PHASE_RECORDS = 2;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    crv_stream_if #(.payload_t(crv_in_t))  record_ch ();
    crv_stream_if #(.payload_t(crv_out_t)) result_ch ();

    int          mismatches;
    int          pending;
    int          checked;
    logic [6:0]  statuses_seen;

    // Stimulus knobs and bookkeeping
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_requests;
    int          bytes_sent;
    int          records_sent;
    int          cycle_count;
    logic [31:0] cur_fmt;
    logic [31:0] cur_sch;
    logic [7:0]  rec_bytes[$];

    current_record_validator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .record    (record_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    crv_result_checker status_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (record_ch.valid),
        .rec_ready     (record_ch.ready),
        .rec_item      (record_ch.payload),
        .res_valid     (result_ch.valid),
        .res_ready     (result_ch.ready),
        .res_item      (result_ch.payload),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .checked       (checked),
        .statuses_seen (statuses_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: end the run if it ever hangs
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles with %0d results outstanding",
                         cycle_count, pending);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Result receiver: random back-pressure, plus a long hold-off each time
    // the stimulus asks for one. The hold is counted here, not by the sender.
    initial
    begin : receiver
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_done < hold_requests)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one byte, idling at random first; return at the accepting edge.
    // Inputs only move at rising edges, so ready seen at the falling edge is
    // what the next rising edge samples.
    task automatic push_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            record_ch.valid <= 1'b0;
            @(posedge clk);
        end
        record_ch.valid   <= 1'b1;
        record_ch.payload <= '{record_byte: b, last_byte: last};
        @(negedge clk);
        while (!record_ch.ready)
            @(negedge clk);
        @(posedge clk);
        bytes_sent++;
    endtask

    // Send the staged bytes as one record, flag on the final byte
    task automatic send_record();
        foreach (rec_bytes[i])
            push_byte(rec_bytes[i], i == rec_bytes.size() - 1);
        records_sent++;
    endtask

    // Stage a well-formed 28-byte record with a correct trailer
    function automatic void build_record(input logic [31:0] fmt,
                                         input logic [31:0] sch,
                                         input logic [63:0] gen);
        logic [31:0] crc;
        rec_bytes.delete();
        for (int i = 0; i < 8; i++)
            rec_bytes = {rec_bytes, RECORD_MAGIC[i]};
        for (int i = 0; i < 4; i++)
            rec_bytes = {rec_bytes, fmt[8*i +: 8]};
        for (int i = 0; i < 4; i++)
            rec_bytes = {rec_bytes, sch[8*i +: 8]};
        for (int i = 0; i < 8; i++)
            rec_bytes = {rec_bytes, gen[8*i +: 8]};
        crc = '1;
        foreach (rec_bytes[i])
            crc = crc32_byte(crc, rec_bytes[i]);
        crc = ~crc;
        for (int i = 0; i < 4; i++)
            rec_bytes = {rec_bytes, crc[8*i +: 8]};
    endfunction

    // Drop valid and hold until every expected status has come back.
    task automatic settle();
        record_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both expected versions back to back; call only when idle
    task automatic write_versions(input logic [31:0] fmt, input logic [31:0] sch);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FORMAT;
        cfg_data  <= fmt;
        @(posedge clk);
        cfg_index <= REG_SCHEMA;
        cfg_data  <= sch;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_fmt = fmt;
        cur_sch = sch;
    endtask

    // One random record: mostly well formed with random content, the rest
    // corrupted in one place, cut short, run long or plain noise.
    task automatic send_random_record();
        int          kind;
        int          n;
        logic [63:0] gen;
        logic [31:0] fmt;
        logic [31:0] sch;
        kind = $urandom_range(99);
        gen  = {$urandom(), $urandom()};
        if (gen == '0)
            gen = 64'd1;
        fmt = cur_fmt;
        sch = cur_sch;
        if (kind >= 61 && kind < 68)
            fmt = $urandom_range(1) ? (cur_fmt ^ (32'h1 << $urandom_range(31))) : $urandom();
        else if (kind >= 68 && kind < 75)
            sch = $urandom_range(1) ? (cur_sch ^ (32'h1 << $urandom_range(31))) : $urandom();
        else if (kind >= 75 && kind < 80)
            gen = '0;
        build_record(fmt, sch, gen);

        if (kind >= 45 && kind < 53)
            // corrupt one magic byte
            rec_bytes[$urandom_range(7)] ^= 8'h01 << $urandom_range(7);
        else if (kind >= 53 && kind < 61)
            // corrupt a covered byte or the trailer itself
            rec_bytes[$urandom_range(27, 8)] ^= 8'h01 << $urandom_range(7);
        else if (kind >= 80 && kind < 88)
        begin
            n = $urandom_range(27, 1);
            while (rec_bytes.size() > n)
                void'(rec_bytes.pop_back());
        end
        else if (kind >= 88 && kind < 94)
        begin
            n = $urandom_range(12, 1);
            repeat (n) rec_bytes = {rec_bytes, 8'($urandom())};
        end
        else if (kind >= 94)
        begin
            rec_bytes.delete();
            n = $urandom_range(40, 1);
            repeat (n) rec_bytes = {rec_bytes, 8'($urandom())};
        end
        send_record();
    endtask

    // Random records until the phase has moved enough bytes and results;
    // now and then pause the sender until everything has drained.
    task automatic run_random_phase();
        int start_bytes;
        int start_records;
        start_bytes   = bytes_sent;
        start_records = records_sent;
        while (bytes_sent - start_bytes < PHASE_BYTES
               || records_sent - start_records < PHASE_RECORDS)
        begin
            send_random_record();
            if ($urandom_range(9) == 0)
                settle();
        end
    endtask

    initial
    begin : stimulus
        // Drive every input to a known value from time zero
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_FORMAT;
        cfg_data          = '0;
        record_ch.valid   = 1'b0;
        record_ch.payload = '0;
        send_idle_pct     = 37;
        recv_idle_pct     = 70;
        hold_requests     = 0;
        bytes_sent        = 0;
        records_sent      = 0;
        cur_fmt           = 32'd1;   // both versions reset to 1
        cur_sch           = 32'd1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed records, versions still at their reset value ----
        // Flag on the very first byte: shortest possible wrong length
        rec_bytes.delete();
        rec_bytes = {rec_bytes, 8'h00};
        send_record();
        // Clean record with the smallest nonzero generation
        build_record(32'd1, 32'd1, 64'd1);
        send_record();
        // Generation zero, otherwise clean
        build_record(32'd1, 32'd1, 64'd0);
        send_record();
        // Bad last magic byte; it also spoils the checksum, magic wins
        build_record(32'd1, 32'd1, 64'h0123_4567_89AB_CDEF);
        rec_bytes[7] ^= 8'h01;
        send_record();
        // Trailer off by its top bit
        build_record(32'd1, 32'd1, 64'h0123_4567_89AB_CDEF);
        rec_bytes[27] ^= 8'h80;
        send_record();
        // Format and schema mismatches
        build_record(32'd2, 32'd1, 64'h0123_4567_89AB_CDEF);
        send_record();
        build_record(32'd1, 32'd0, 64'h0123_4567_89AB_CDEF);
        send_record();
        // One byte short
        build_record(32'd1, 32'd1, 64'h0123_4567_89AB_CDEF);
        void'(rec_bytes.pop_back());
        send_record();
        // Overlong: trailing all-ones bytes are counted but ignored
        build_record(32'd1, 32'd1, 64'h0123_4567_89AB_CDEF);
        repeat (3) rec_bytes = {rec_bytes, 8'hFF};
        send_record();

        // Extreme versions: all-zero format, all-ones schema
        settle();
        write_versions(32'h0000_0000, 32'hFFFF_FFFF);
        build_record(32'h0000_0000, 32'hFFFF_FFFF, '1);
        send_record();
        build_record(32'hFFFF_FFFF, 32'h0000_0000, '1);
        send_record();

        // ---- Random: sender idles often, receiver idles more ----
        run_random_phase();

        // ---- Random, other idle mix, opposite extremes ----
        settle();
        write_versions(32'hFFFF_FFFF, 32'h0000_0000);
        send_idle_pct = 70;
        recv_idle_pct = 37;
        run_random_phase();

        // ---- No idling, random versions ----
        settle();
        write_versions($urandom(), $urandom());
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Hold the receiver off while flagged single bytes keep coming: the
        // result buffer fills and the block must stall its input.
        hold_requests++;
        repeat (12)
        begin
            rec_bytes.delete();
            rec_bytes = {rec_bytes, 8'($urandom())};
            send_record();
        end
        settle();
        run_random_phase();

        // ---- Drain and decide ----
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d bytes in %0d records under three idle mixes; %0d statuses checked",
                 bytes_sent, records_sent, checked);
        $display("Status codes returned (one bit per code, 6 down to 0): %b", statuses_seen);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
